### design/url_query_string_parser_macros.svh
// Assertion macros for the query string parser checks
`ifndef URL_QUERY_STRING_PARSER_MACROS_SVH
`define URL_QUERY_STRING_PARSER_MACROS_SVH

// same-cycle implication, reset masked
`define UQSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uqsp check failed");

// next-cycle implication, reset masked
`define UQSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uqsp check failed");

`endif

### design/uqsp_pkg.sv
// Shared types and constants of the query string parser
package uqsp_pkg;

  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_AMP    = 8'h26;

  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NO_QUERY    = 3'd1;
  localparam logic [2:0] ERR_EMPTY_QUERY = 3'd2;
  localparam logic [2:0] ERR_EMPTY_KEY   = 3'd3;
  localparam logic [2:0] ERR_KEY_LONG    = 3'd4;
  localparam logic [2:0] ERR_EMPTY_VALUE = 3'd5;
  localparam logic [2:0] ERR_VALUE_LONG  = 3'd6;

  localparam logic [6:0] MAX_PARAMS_RST = 7'd8;
  localparam logic [6:0] CAP_MAX        = 7'd64;
  localparam logic [6:0] CAP_MIN        = 7'd1;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_path;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [6:0] param_index;
    logic [2:0] error_code;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [2:0] {
    MODE_BEFORE,
    MODE_KEY,
    MODE_VALUE,
    MODE_SKIP,
    MODE_FULL
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_VAL,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_KEY,
    SRC_VAL
  } src_t;

  // one result on its way from the controller to the output stage
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [6:0] idx;
    logic [2:0] err;
    logic       last;
    src_t       src;
  } issue_t;

endpackage

### design/uqsp_field_mem.sv
// Field byte store: one write port, one registered read port
module uqsp_field_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/uqsp_out_stage.sv
// Read-data stage and output register of the result channel
module uqsp_out_stage
  import uqsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  issue_t    issue,
  input  logic [7:0] key_rdata,
  input  logic [7:0] val_rdata,
  output logic      s1_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic      s1_v_r, s1_v_nxt;
  issue_t    s1_r;
  logic      out_v_r, out_v_nxt;
  out_word_t out_r, out_nxt;
  logic      out_load;

  assign out_load = s1_v_r && (!out_v_r || out_ready);
  assign s1_free  = !s1_v_r || out_load;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue.valid) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_nxt.kind        = s1_r.kind;
    out_nxt.param_index = s1_r.idx;
    out_nxt.error_code  = s1_r.err;
    out_nxt.last_of_run = s1_r.last;
    case (s1_r.src)
      SRC_KEY: out_nxt.out_byte = key_rdata;
      SRC_VAL: out_nxt.out_byte = val_rdata;
      default: out_nxt.out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue.valid) begin
      s1_r <= issue;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

endmodule

### design/uqsp_ctrl.sv
// Parser state, capacity register and key/value replay sequencer
module uqsp_ctrl
  import uqsp_pkg::*;
#(
  parameter int MAX_FIELD_LEN = 32,
  parameter int LW            = 5
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_word_t      in_word,
  input  logic          cfg_valid,
  input  logic [6:0]    cfg_data,
  input  logic          s1_free,
  output issue_t        issue,
  output logic          key_we,
  output logic          val_we,
  output logic [LW-1:0] key_waddr,
  output logic [LW-1:0] val_waddr,
  output logic [7:0]    wdata,
  output logic          key_re,
  output logic          val_re,
  output logic [LW-1:0] raddr
);

  localparam logic [LW-1:0] LEN_TOP = LW'(MAX_FIELD_LEN - 1);

  ctrl_state_t   state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [LW-1:0] klen_r, klen_nxt;
  logic [LW-1:0] vlen_r, vlen_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [6:0]    pcnt_r, pcnt_nxt;
  logic          eop_pend_r, eop_pend_nxt;
  logic [6:0]    max_params_r;

  logic          accept;
  logic [2:0]    p_err;
  logic          p_pair;
  logic          p_done;
  logic          p_kwe;
  logic          p_vwe;
  mode_t         p_mode;
  logic          eop;
  logic [6:0]    cap;
  logic [6:0]    pcnt_inc;
  logic          key_last;
  logic          val_last;

  assign eop      = in_word.end_of_path;
  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && s1_free;
  assign pcnt_inc = pcnt_r + 7'd1;
  assign key_last = (cnt_r == klen_r - LW'(1));
  assign val_last = (cnt_r == vlen_r - LW'(1));

  always_comb begin
    if (max_params_r == 7'd0) begin
      cap = CAP_MIN;
    end else if (max_params_r > CAP_MAX) begin
      cap = CAP_MAX;
    end else begin
      cap = max_params_r;
    end
  end

  // character decode for the current mode
  always_comb begin
    p_err  = ERR_NONE;
    p_pair = 1'b0;
    p_done = 1'b0;
    p_kwe  = 1'b0;
    p_vwe  = 1'b0;
    p_mode = mode_r;
    case (mode_r)
      MODE_BEFORE: begin
        if (in_word.ch == CH_QUERY) begin
          if (eop) p_err = ERR_EMPTY_QUERY;
          else     p_mode = MODE_KEY;
        end else if (eop) begin
          p_err = ERR_NO_QUERY;
        end
      end
      MODE_KEY: begin
        if (in_word.ch == CH_EQUALS) begin
          if (klen_r == '0) p_err = ERR_EMPTY_KEY;
          else if (eop)     p_err = ERR_EMPTY_VALUE;
          else              p_mode = MODE_VALUE;
        end else if (in_word.ch == CH_AMP) begin
          p_err = (klen_r == '0) ? ERR_EMPTY_KEY : ERR_EMPTY_VALUE;
        end else if (klen_r == LEN_TOP) begin
          p_err = ERR_KEY_LONG;
        end else begin
          p_kwe = 1'b1;
          if (eop) p_err = ERR_EMPTY_VALUE;
        end
      end
      MODE_VALUE: begin
        if (in_word.ch == CH_AMP) begin
          if (vlen_r == '0) p_err = ERR_EMPTY_VALUE;
          else              p_pair = 1'b1;
        end else if (vlen_r == LEN_TOP) begin
          p_err = ERR_VALUE_LONG;
        end else begin
          p_vwe = 1'b1;
          if (eop) p_pair = 1'b1;
        end
      end
      MODE_FULL: begin
        p_done = eop;
      end
      default: begin
      end
    endcase
  end

  // next state of the sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && p_pair) state_nxt = ST_KEY;
      end
      ST_KEY: begin
        if (s1_free && key_last) state_nxt = ST_VAL;
      end
      ST_VAL: begin
        if (s1_free && val_last) state_nxt = eop_pend_r ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (s1_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // parser registers
  always_comb begin
    mode_nxt     = mode_r;
    klen_nxt     = klen_r;
    vlen_nxt     = vlen_r;
    cnt_nxt      = cnt_r;
    pcnt_nxt     = pcnt_r;
    eop_pend_nxt = eop_pend_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (p_err != ERR_NONE) begin
            mode_nxt = MODE_SKIP;
          end else begin
            mode_nxt = p_mode;
          end
          if (p_kwe) klen_nxt = klen_r + LW'(1);
          if (p_vwe) vlen_nxt = vlen_r + LW'(1);
          if (p_pair) begin
            cnt_nxt      = '0;
            eop_pend_nxt = eop;
          end else if (eop) begin
            mode_nxt = MODE_BEFORE;
            klen_nxt = '0;
            vlen_nxt = '0;
            pcnt_nxt = '0;
          end
        end
      end
      ST_KEY: begin
        if (s1_free) cnt_nxt = key_last ? '0 : cnt_r + LW'(1);
      end
      ST_VAL: begin
        if (s1_free) begin
          cnt_nxt = cnt_r + LW'(1);
          if (val_last) begin
            cnt_nxt  = '0;
            klen_nxt = '0;
            vlen_nxt = '0;
            pcnt_nxt = pcnt_inc;
            mode_nxt = (pcnt_inc >= cap) ? MODE_FULL : MODE_KEY;
          end
        end
      end
      ST_DONE: begin
        if (s1_free) begin
          mode_nxt = MODE_BEFORE;
          pcnt_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // result issue and memory ports
  always_comb begin
    issue.valid = 1'b0;
    issue.kind  = KIND_ERROR;
    issue.idx   = 7'd0;
    issue.err   = ERR_NONE;
    issue.last  = 1'b1;
    issue.src   = SRC_NONE;
    case (state_r)
      ST_IDLE: begin
        issue.valid = accept && ((p_err != ERR_NONE) || p_done);
        if (p_err != ERR_NONE) begin
          issue.kind = KIND_ERROR;
          issue.err  = p_err;
        end else begin
          issue.kind = KIND_DONE;
          issue.idx  = pcnt_r;
        end
      end
      ST_KEY: begin
        issue.valid = s1_free;
        issue.kind  = KIND_KEY;
        issue.idx   = pcnt_r;
        issue.last  = 1'b0;
        issue.src   = SRC_KEY;
      end
      ST_VAL: begin
        issue.valid = s1_free;
        issue.kind  = KIND_VALUE;
        issue.idx   = pcnt_r;
        issue.last  = val_last && !eop_pend_r;
        issue.src   = SRC_VAL;
      end
      ST_DONE: begin
        issue.valid = s1_free;
        issue.kind  = KIND_DONE;
        issue.idx   = pcnt_r;
      end
      default: begin
      end
    endcase
  end

  assign key_we    = accept && p_kwe;
  assign val_we    = accept && p_vwe;
  assign key_waddr = klen_r;
  assign val_waddr = vlen_r;
  assign wdata     = in_word.ch;
  assign key_re    = issue.valid && (issue.src == SRC_KEY);
  assign val_re    = issue.valid && (issue.src == SRC_VAL);
  assign raddr     = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_BEFORE;
      klen_r       <= '0;
      vlen_r       <= '0;
      cnt_r        <= '0;
      pcnt_r       <= '0;
      eop_pend_r   <= 1'b0;
      max_params_r <= MAX_PARAMS_RST;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      klen_r     <= klen_nxt;
      vlen_r     <= vlen_nxt;
      cnt_r      <= cnt_nxt;
      pcnt_r     <= pcnt_nxt;
      eop_pend_r <= eop_pend_nxt;
      if (cfg_valid) begin
        max_params_r <= cfg_data;
      end
    end
  end

endmodule

### design/url_query_string_parser.sv
// Query string parser: takes path characters and emits key/value bytes, done or error
// Takes one path character per cycle while no pair is being replayed and the result
// side is free. A character that closes a pair starts a replay of the stored key and
// value, one byte per cycle while the result side is free, from the read port of the
// key or value memory, plus a done word at the end of the path; no character is taken
// during that replay. Error words, and done words of a path whose pair limit was
// already reached, are issued in the cycle their character is taken. Results go
// through a read-data stage and an output register, so a stalled result side holds
// the parser only once both are full. The capacity register may be written at any
// time the block is idle and is always ready.
module url_query_string_parser
  import uqsp_pkg::*;
#(
  parameter int MAX_FIELD_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int LW = $clog2(MAX_FIELD_LEN);

  issue_t        issue;
  logic          s1_free;
  logic          key_we, val_we, key_re, val_re;
  logic [LW-1:0] key_waddr, val_waddr, raddr;
  logic [7:0]    wdata, key_rdata, val_rdata;

  assign cfg_ready = 1'b1;

  uqsp_ctrl #(
    .MAX_FIELD_LEN(MAX_FIELD_LEN),
    .LW           (LW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .cfg_valid(cfg_valid),
    .cfg_data (cfg_data),
    .s1_free  (s1_free),
    .issue    (issue),
    .key_we   (key_we),
    .val_we   (val_we),
    .key_waddr(key_waddr),
    .val_waddr(val_waddr),
    .wdata    (wdata),
    .key_re   (key_re),
    .val_re   (val_re),
    .raddr    (raddr)
  );

  uqsp_field_mem #(
    .DEPTH(MAX_FIELD_LEN),
    .AW   (LW)
  ) u_key_mem (
    .clk  (clk),
    .we   (key_we),
    .waddr(key_waddr),
    .wdata(wdata),
    .re   (key_re),
    .raddr(raddr),
    .rdata(key_rdata)
  );

  uqsp_field_mem #(
    .DEPTH(MAX_FIELD_LEN),
    .AW   (LW)
  ) u_val_mem (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(wdata),
    .re   (val_re),
    .raddr(raddr),
    .rdata(val_rdata)
  );

  uqsp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .key_rdata(key_rdata),
    .val_rdata(val_rdata),
    .s1_free  (s1_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

endmodule

### design/uqsp_checker.sv
// Port-level checks of the query string parser and their bind
`include "url_query_string_parser_macros.svh"

module uqsp_checker
  import uqsp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  logic err_fields_ok;
  logic done_fields_ok;
  logic key_fields_ok;

  assign err_fields_ok  = (out_word.error_code != ERR_NONE) &&
                          (out_word.param_index == 7'd0) &&
                          (out_word.out_byte == 8'd0) && out_word.last_of_run;
  assign done_fields_ok = (out_word.error_code == ERR_NONE) &&
                          (out_word.out_byte == 8'd0) && out_word.last_of_run;
  assign key_fields_ok  = !out_word.last_of_run && (out_word.error_code == ERR_NONE);

  // error words carry only the code
  `UQSP_ASSERT_IMP(a_err_word, out_valid && (out_word.kind == KIND_ERROR), err_fields_ok)

  // done always closes the run
  `UQSP_ASSERT_IMP(a_done_word, out_valid && (out_word.kind == KIND_DONE), done_fields_ok)

  // key bytes never close the run and carry no error code
  `UQSP_ASSERT_IMP(a_key_not_last, out_valid && (out_word.kind == KIND_KEY), key_fields_ok)

  // stalled result word holds
  `UQSP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

  // offered path word holds until taken
  `UQSP_ASSERT_NXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_word))

endmodule

bind url_query_string_parser uqsp_checker u_uqsp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_word  (in_word),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
